>>> rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, register indexes and controller/datapath interface types
// for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);
    localparam int IDX_W = 1;

    localparam logic [IDX_W-1:0] REG_MODULUS  = 1'b0;
    localparam logic [IDX_W-1:0] REG_EXPONENT = 1'b1;

    localparam logic [WIDTH-1:0] MODULUS_RST  = WIDTH'(1);
    localparam logic [WIDTH-1:0] EXPONENT_RST = '0;

    typedef struct packed {
        logic load;
        logic start_mul;
        logic start_sqr;
        logic step;
        logic wb_base;
        logic wb_acc;
        logic shift_exp;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic exp_zero;
        logic exp_lsb;
        logic out_free;
    } status_t;

endpackage

>>> rtl/mexp_ctrl.sv
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer: reduces the base, then walks the exponent bits issuing one
// bit-serial modular multiply per set bit and one square per bit.
// ----------------------------------------------------------------------------
module mexp_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mexp_pkg::status_t    status,
    output mexp_pkg::cmd_t       cmd
);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_RED     = 7'b0000010,
        ST_CHECK   = 7'b0000100,
        ST_MUL     = 7'b0001000,
        ST_LOADSQR = 7'b0010000,
        ST_SQR     = 7'b0100000,
        ST_DONE    = 7'b1000000
    } state_t;

    localparam logic [mexp_pkg::CNT_W-1:0] CNT_LAST = mexp_pkg::CNT_W'(mexp_pkg::WIDTH - 1);

    state_t                      state_reg, state_next;
    logic [mexp_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                        last;

    assign last     = (cnt_reg == '0);
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = CNT_LAST;
                    state_next = ST_RED;
                end
            end
            ST_RED:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (last)
                begin
                    cmd.wb_base = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cnt_next = CNT_LAST;
                if (status.exp_zero)
                begin
                    state_next = ST_DONE;
                end
                else if (status.exp_lsb)
                begin
                    cmd.start_mul = 1'b1;
                    state_next    = ST_MUL;
                end
                else
                begin
                    cmd.start_sqr = 1'b1;
                    state_next    = ST_SQR;
                end
            end
            ST_MUL:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (last)
                begin
                    cmd.wb_acc = 1'b1;
                    state_next = ST_LOADSQR;
                end
            end
            ST_LOADSQR:
            begin
                cmd.start_sqr = 1'b1;
                cnt_next      = CNT_LAST;
                state_next    = ST_SQR;
            end
            ST_SQR:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (last)
                begin
                    cmd.wb_base   = 1'b1;
                    cmd.shift_exp = 1'b1;
                    state_next    = ST_CHECK;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> rtl/mexp_dp.sv
// ----------------------------------------------------------------------------
// mexp_dp
// Datapath: configuration registers, base/accumulator/exponent registers,
// a one-bit-per-cycle modular multiply-add step and the output register.
// ----------------------------------------------------------------------------
module mexp_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mexp_pkg::IDX_W-1:0]    cfg_index,
    input  logic [mexp_pkg::WIDTH-1:0]    cfg_data,
    input  logic [mexp_pkg::WIDTH-1:0]    in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mexp_pkg::WIDTH-1:0]    out_data,
    input  mexp_pkg::cmd_t                cmd,
    output mexp_pkg::status_t             status
);

    localparam int W = mexp_pkg::WIDTH;

    logic [W-1:0] modulus_reg;
    logic [W-1:0] exponent_reg;
    logic [W-1:0] base_reg;
    logic [W-1:0] acc_reg;
    logic [W-1:0] exp_reg;
    logic [W-1:0] a_reg;
    logic [W-1:0] b_reg;
    logic [W-1:0] p_reg;
    logic [W-1:0] p_next;
    logic [W-1:0] out_data_reg;
    logic         out_valid_reg;

    logic [W+1:0] t;
    logic [W+1:0] m1;
    logic [W+1:0] m2;
    logic         mzero;

    assign mzero = (modulus_reg == '0);
    assign m1    = {2'b00, modulus_reg};
    assign m2    = {1'b0, modulus_reg, 1'b0};
    assign t     = {1'b0, p_reg, 1'b0} + (b_reg[W-1] ? {2'b00, a_reg} : '0);

    always_comb
    begin
        if (mzero)
        begin
            p_next = t[W-1:0];
        end
        else if (t >= m2)
        begin
            p_next = W'(t - m2);
        end
        else if (t >= m1)
        begin
            p_next = W'(t - m1);
        end
        else
        begin
            p_next = t[W-1:0];
        end
    end

    assign status.exp_zero = (exp_reg == '0);
    assign status.exp_lsb  = exp_reg[0];
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= mexp_pkg::MODULUS_RST;
            exponent_reg <= mexp_pkg::EXPONENT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mexp_pkg::REG_MODULUS:  modulus_reg  <= cfg_data;
                mexp_pkg::REG_EXPONENT: exponent_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= acc_reg;
        end
        if (cmd.load)
        begin
            a_reg   <= W'(1);
            b_reg   <= in_data;
            p_reg   <= '0;
            acc_reg <= W'(1);
            exp_reg <= exponent_reg;
        end
        else if (cmd.start_mul)
        begin
            a_reg <= acc_reg;
            b_reg <= base_reg;
            p_reg <= '0;
        end
        else if (cmd.start_sqr)
        begin
            a_reg <= base_reg;
            b_reg <= base_reg;
            p_reg <= '0;
        end
        else if (cmd.step)
        begin
            b_reg <= {b_reg[W-2:0], 1'b0};
            p_reg <= p_next;
        end
        if (cmd.wb_base)
        begin
            base_reg <= p_next;
        end
        if (cmd.wb_acc)
        begin
            acc_reg <= p_next;
        end
        if (cmd.shift_exp)
        begin
            exp_reg <= {1'b0, exp_reg[W-1:1]};
        end
    end

endmodule

>>> rtl/modular_exponentiation_top.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// Modular exponentiation, right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// Each base word is raised to the configured exponent modulo the configured
// modulus; one result word per input word. One item is processed at a time.
// The base is first reduced, then each exponent bit up to the highest set
// bit costs a square, plus a multiply when the bit is set, each modular
// multiply being a shift-and-add reduced one multiplier bit per cycle. The
// next base word is taken in the cycle after the result is loaded. An
// exponent of zero returns 1; a modulus of zero means plain 32-bit
// wrap-around. The output register lets a new word be taken while the
// previous result is still waiting.
// ----------------------------------------------------------------------------
module modular_exponentiation_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mexp_pkg::IDX_W-1:0]       cfg_index,
    input  logic [mexp_pkg::WIDTH-1:0]       cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mexp_pkg::WIDTH-1:0]       s_tdata,   // [31:0] base_value
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mexp_pkg::WIDTH-1:0]       m_tdata    // [31:0] power_result
);

    mexp_pkg::cmd_t    cmd;
    mexp_pkg::status_t status;

    mexp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mexp_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
